FILE: hdl/sccbw_pkg.sv
package sccbw_pkg;

    // command codes carried in the func field
    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_WRITE   = 3'd4
    } cmd_t;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACK_HOLD_TICKS = 2'd1;
    localparam int CFG_DATA_WIDTH = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  PHASE_TICKS_RESET    = 8'd1;
    localparam logic [15:0] ACK_HOLD_TICKS_RESET = 16'd1000;

    // phase numbering of the write sequence
    localparam int STEP_WIDTH = 5;
    localparam logic [STEP_WIDTH-1:0] STEP_DATA_END    = 5'd24;
    localparam logic [STEP_WIDTH-1:0] STEP_ACK_RELEASE = 5'd24;
    localparam logic [STEP_WIDTH-1:0] STEP_ACK_HOLD    = 5'd25;
    localparam logic [STEP_WIDTH-1:0] STEP_ACK_SAMPLE  = 5'd26;

    // sub-phases of one data bit
    localparam logic [1:0] SUB_DATA  = 2'd0;
    localparam logic [1:0] SUB_CLK_H = 2'd1;
    localparam logic [1:0] SUB_CLK_L = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] wdata;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic busy_res;
        logic done_res;
        logic ack_ok;
    } out_t;

    typedef struct packed {
        logic [7:0]  phase_ticks;
        logic [15:0] ack_hold_ticks;
    } cfg_t;

    // number of phases in each command sequence
    function automatic logic [STEP_WIDTH-1:0] phase_count(input cmd_t cmd);
        logic [STEP_WIDTH-1:0] n;
        case (cmd)
            CMD_RELEASE: n = 5'd1;
            CMD_START:   n = 5'd4;
            CMD_STOP:    n = 5'd3;
            CMD_WRITE:   n = 5'd27;
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/sccbw_core.sv
module sccbw_core #(
    parameter int WAIT_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  sccbw_pkg::in_t  in_data,
    input  sccbw_pkg::cfg_t cfg,
    output sccbw_pkg::out_t result
);
    import sccbw_pkg::*;

    localparam logic [32:0] WAIT_LIMIT = (33'd1 << WAIT_WIDTH) - 33'd1;

    cmd_t                  cmd_reg, cmd_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic [1:0]            sub_reg, sub_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [WAIT_WIDTH-1:0] wait_next_sel;
    logic [7:0]            shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_reg, ack_next;
    logic                  done;
    logic                  enter;
    logic [STEP_WIDTH-1:0] step_inc;
    logic [15:0]           dur_raw;
    logic [15:0]           dur_m1;
    logic [32:0]           dur_wide;
    logic [WAIT_WIDTH-1:0] dur_sat;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            step_reg  <= '0;
            sub_reg   <= SUB_DATA;
            wait_reg  <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            sub_reg   <= sub_next;
            wait_reg  <= wait_next_sel;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
        end
    end

    // hold length of the phase being entered, less one, saturated to the counter
    always_comb
    begin
        if (cmd_next == CMD_RELEASE)
            dur_raw = 16'd1;
        else if (cmd_next == CMD_WRITE && step_next == STEP_ACK_HOLD)
            dur_raw = cfg.ack_hold_ticks;
        else
            dur_raw = {8'd0, cfg.phase_ticks};
        dur_m1   = (dur_raw == 16'd0) ? 16'd0 : dur_raw - 16'd1;
        dur_wide = {17'd0, dur_m1};
        dur_sat  = (dur_wide > WAIT_LIMIT) ? {WAIT_WIDTH{1'b1}} : dur_wide[WAIT_WIDTH-1:0];
    end

    // sequencer: command start, hold countdown, phase advance
    always_comb
    begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        sub_next   = sub_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        done       = 1'b0;
        enter      = 1'b0;
        step_inc   = step_reg + 5'd1;

        if (cmd_reg == CMD_IDLE)
        begin
            if (in_data.func >= CMD_RELEASE && in_data.func <= CMD_WRITE)
            begin
                cmd_next  = cmd_t'(in_data.func);
                step_next = '0;
                sub_next  = SUB_DATA;
                if (in_data.func == CMD_WRITE)
                    shift_next = in_data.wdata;
                enter = 1'b1;
            end
        end
        else if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else if (step_inc >= phase_count(cmd_reg))
        begin
            cmd_next  = CMD_IDLE;
            step_next = '0;
            sub_next  = SUB_DATA;
            wait_next = '0;
            done      = 1'b1;
        end
        else
        begin
            step_next = step_inc;
            sub_next  = (sub_reg == SUB_CLK_L) ? SUB_DATA : sub_reg + 2'd1;
            // next data bit moves up to the msb
            if (cmd_reg == CMD_WRITE && step_inc < STEP_DATA_END && sub_next == SUB_DATA)
                shift_next = {shift_reg[6:0], 1'b0};
            enter = 1'b1;
        end
    end

    // line levels set on entry to a phase
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        ack_next = ack_reg;
        if (enter)
        begin
            case (cmd_next)
                CMD_RELEASE:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                CMD_START:
                begin
                    case (step_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                CMD_STOP:
                begin
                    case (step_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                default:
                begin
                    if (step_next < STEP_DATA_END)
                    begin
                        case (sub_next)
                            SUB_DATA:  sda_next = shift_next[7];
                            SUB_CLK_H: scl_next = 1'b1;
                            default:   scl_next = 1'b0;
                        endcase
                    end
                    else if (step_next == STEP_ACK_RELEASE)
                        sda_next = 1'b1;
                    else if (step_next == STEP_ACK_HOLD)
                        scl_next = 1'b1;
                    else
                    begin
                        ack_next = ~in_data.sda_in;
                        scl_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // hold counter loads the new phase length on entry
    always_comb
    begin
        if (enter)
            wait_next_sel = dur_sat;
        else
            wait_next_sel = wait_next;
    end

    assign result.scl_out  = scl_next;
    assign result.sda_out  = sda_next;
    assign result.busy_res = (cmd_next != CMD_IDLE);
    assign result.done_res = done;
    assign result.ack_ok   = ack_next;

    // idle sequencer carries no leftover phase or hold
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_IDLE |-> step_reg == '0 && wait_reg == '0)
        else $error("idle with pending phase state");

    // phase index stays inside the sequence of the active command
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg != CMD_IDLE |-> step_reg < phase_count(cmd_reg))
        else $error("phase index past end of sequence");

    // done only ends an active sequence and leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && done |=> cmd_reg == CMD_IDLE && $past(cmd_reg) != CMD_IDLE)
        else $error("done without an active sequence");

    // sda released while scl is high during the acknowledge hold
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg == CMD_WRITE && step_reg == STEP_ACK_HOLD |-> sda_reg && scl_reg)
        else $error("sda driven during acknowledge");

endmodule

FILE: hdl/sccb_master_byte_writer.sv
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, in_data (func...)     | input
// out     | out_valid, out_ready, out_data (scl...)   | output
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input
//
// one tick item in, one result out; a tick can be taken every clock unless a result waits and out_ready is low
// the result is registered and offered the cycle after its tick transfer
// reset drives both bus lines released (1), idle, config to phase 1 / ack hold 1000
// in_ready drops only while a result waits and out_ready is low
// cfg writes are always ready and take effect on the next tick
module sccb_master_byte_writer #(
    parameter int WAIT_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  sccbw_pkg::in_t                           in_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output sccbw_pkg::out_t                          out_data,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [sccbw_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [sccbw_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import sccbw_pkg::*;

    cfg_t  cfg_reg;
    logic  out_valid_reg;
    out_t  out_data_reg;
    out_t  result;
    logic  step_en;

    assign step_en   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks    <= PHASE_TICKS_RESET;
            cfg_reg.ack_hold_ticks <= ACK_HOLD_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg_data[7:0];
                CFG_ACK_HOLD_TICKS: cfg_reg.ack_hold_ticks <= cfg_data;
                default:            ;
            endcase
        end
    end

    sccbw_core #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .in_data (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step_en)
            out_data_reg <= result;
    end

    // every accepted tick leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // a result not taken blocks the next tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_ready)
        else $error("tick accepted over a pending result");

    // done and busy never flag together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.done_res && out_data_reg.busy_res))
        else $error("done reported while busy");

endmodule

FILE: tb/sccbw_checker.sv
`timescale 1ns / 100ps

module sccbw_checker #(
    parameter int WAIT_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  sccbw_pkg::in_t                        in_data,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  sccbw_pkg::out_t                       out_data,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [sccbw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sccbw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                    fail_count,
    output int unsigned                           levels_owed,
    output logic                                  seq_running
);
    import sccbw_pkg::*;

    localparam int REPORT_LIMIT = 40;

    // predicted sequencer state
    cmd_t            bus_cmd;
    logic [5:0]      step_no;
    longint unsigned hold_left;
    logic [7:0]      tx_byte;
    logic            scl_lvl;
    logic            sda_lvl;
    logic            ack_seen;

    // predicted register contents
    logic [7:0]      ticks_per_phase;
    logic [15:0]     ack_hold;

    // bus levels still owed by the block, oldest first
    out_t            levels_due [$];
    out_t            want;

    // number of phases in each command sequence
    function automatic logic [5:0] seq_phases(input cmd_t cmd);
        case (cmd)
            CMD_RELEASE: return 6'd1;
            CMD_START:   return 6'd4;
            CMD_STOP:    return 6'd3;
            CMD_WRITE:   return 6'd27;
            default:     return 6'd0;
        endcase
    endfunction

    // extra ticks a phase holds after the one that enters it
    function automatic longint unsigned hold_len(input cmd_t cmd, input logic [5:0] step);
        longint unsigned d;
        longint unsigned ceiling;
        ceiling = (64'd1 << WAIT_WIDTH) - 64'd1;
        if (cmd == CMD_RELEASE)
            d = 1;
        else if (cmd == CMD_WRITE && step == STEP_ACK_HOLD)
            d = 64'(ack_hold);
        else
            d = 64'(ticks_per_phase);
        // zero register reads as one tick
        if (d == 0)
            d = 1;
        d = d - 1;
        return (d > ceiling) ? ceiling : d;
    endfunction

    // set the line level of the phase being entered
    function automatic void enter_step(input logic sda_seen);
        logic [2:0] bit_no;
        logic [1:0] sub;
        bit_no = 3'(step_no / 3);
        sub = 2'(step_no % 3);
        case (bus_cmd)
            CMD_RELEASE:
            begin
                scl_lvl = 1'b1;
                sda_lvl = 1'b1;
            end
            CMD_START:
            begin
                case (step_no)
                    6'd0:    sda_lvl = 1'b1;
                    6'd1:    scl_lvl = 1'b1;
                    6'd2:    sda_lvl = 1'b0;
                    default: scl_lvl = 1'b0;
                endcase
            end
            CMD_STOP:
            begin
                case (step_no)
                    6'd0:    sda_lvl = 1'b0;
                    6'd1:    scl_lvl = 1'b1;
                    default: sda_lvl = 1'b1;
                endcase
            end
            default:
            begin
                // data bits msb first, then release, ack clock high, sample and drop
                if (step_no < STEP_DATA_END)
                begin
                    if (sub == SUB_DATA)
                        sda_lvl = tx_byte[7 - bit_no];
                    else
                        scl_lvl = (sub == SUB_CLK_H);
                end
                else if (step_no == STEP_ACK_RELEASE)
                    sda_lvl = 1'b1;
                else if (step_no == STEP_ACK_HOLD)
                    scl_lvl = 1'b1;
                else
                begin
                    ack_seen = !sda_seen;
                    scl_lvl = 1'b0;
                end
            end
        endcase
        hold_left = hold_len(bus_cmd, step_no);
    endfunction

    // advance one tick and return the bus levels it produces
    function automatic out_t bus_tick(input in_t item);
        out_t res;
        logic finished;
        finished = 1'b0;
        if (bus_cmd == CMD_IDLE)
        begin
            // commands only start from idle, unknown codes fall through
            if (item.func >= CMD_RELEASE && item.func <= CMD_WRITE)
            begin
                bus_cmd = cmd_t'(item.func);
                step_no = '0;
                if (bus_cmd == CMD_WRITE)
                    tx_byte = item.wdata;
                enter_step(item.sda_in);
            end
        end
        else if (hold_left != 0)
            hold_left = hold_left - 1;
        else
        begin
            step_no = step_no + 6'd1;
            if (step_no >= seq_phases(bus_cmd))
            begin
                bus_cmd = CMD_IDLE;
                step_no = '0;
                hold_left = 0;
                finished = 1'b1;
            end
            else
                enter_step(item.sda_in);
        end
        res.scl_out = scl_lvl;
        res.sda_out = sda_lvl;
        res.busy_res = (bus_cmd != CMD_IDLE);
        res.done_res = finished;
        res.ack_ok = ack_seen;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic exp_v, input logic got_v);
        if (exp_v !== got_v)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0b got %0b", $time, name, exp_v, got_v);
        end
    endfunction

    // track register writes, predict each tick, compare each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_cmd = CMD_IDLE;
            step_no = '0;
            hold_left = 0;
            tx_byte = '0;
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
            ack_seen = 1'b0;
            ticks_per_phase = PHASE_TICKS_RESET;
            ack_hold = ACK_HOLD_TICKS_RESET;
            levels_due.delete();
            fail_count = 0;
            levels_owed <= 0;
            seq_running <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PHASE_TICKS:    ticks_per_phase = cfg_data[7:0];
                    CFG_ACK_HOLD_TICKS: ack_hold = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (levels_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result expected none got %b", $time, out_data);
                end
                else
                begin
                    want = levels_due.pop_front();
                    check_field("scl_out", want.scl_out, out_data.scl_out);
                    check_field("sda_out", want.sda_out, out_data.sda_out);
                    check_field("busy_res", want.busy_res, out_data.busy_res);
                    check_field("done_res", want.done_res, out_data.done_res);
                    check_field("ack_ok", want.ack_ok, out_data.ack_ok);
                end
            end
            if (in_valid && in_ready)
                levels_due.push_back(bus_tick(in_data));
            levels_owed <= levels_due.size();
            seq_running <= (bus_cmd != CMD_IDLE);
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import sccbw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned BURST_TICKS = 135;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
    localparam logic [2:0] FUNC_RSVD_LAST = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    int          fail_count;
    int unsigned levels_owed;
    logic        seq_running;

    bit          calm = 1'b0;
    bit          hold_wanted = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned ticks_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sccb_master_byte_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sccbw_checker bus_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .levels_owed (levels_owed),
        .seq_running (seq_running)
    );

    // offer one tick and wait for its transfer, with an occasional gap first
    task automatic send_tick(input in_t item);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    // issue a command, then keep ticking until the sequencer goes idle again
    task automatic run_seq(input logic [2:0] code, input logic [7:0] data_byte,
                           input logic ack_level, input bit scramble);
        in_t item;
        item.func = code;
        item.wdata = data_byte;
        item.sda_in = scramble ? 1'($urandom) : ack_level;
        send_tick(item);
        do
        begin
            // stray commands while busy should be dropped
            if (scramble && $urandom_range(0, 4) == 0)
                item.func = 3'($urandom_range(0, 7));
            else
                item.func = CMD_IDLE;
            item.wdata = 8'($urandom);
            if (scramble)
                item.sda_in = 1'($urandom);
            send_tick(item);
        end
        while (seq_running);
    endtask

    // run out any sequence in flight and collect every result
    task automatic settle();
        in_t item;
        do
        begin
            item.func = CMD_IDLE;
            item.wdata = 8'($urandom);
            item.sda_in = 1'($urandom);
            send_tick(item);
        end
        while (seq_running);
        in_valid <= 1'b0;
        do @(posedge clk); while (levels_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only with the block idle and drained
    task automatic set_config(input logic [7:0] phase, input logic [15:0] hold);
        logic [7:0] junk;
        junk = 8'($urandom);
        settle();
        write_reg(CFG_PHASE_TICKS, {junk, phase});
        write_reg(CFG_ACK_HOLD_TICKS, hold);
    endtask

    // random command mix, writes weighted up, until the tick quota is spent
    task automatic random_burst(input int unsigned quota);
        int unsigned first;
        int unsigned pick;
        logic [2:0] code;
        first = ticks_sent;
        while (ticks_sent - first < quota)
        begin
            pick = $urandom_range(0, 11);
            if (pick < 5)
                code = CMD_WRITE;
            else if (pick < 7)
                code = CMD_START;
            else if (pick < 9)
                code = CMD_STOP;
            else if (pick < 10)
                code = CMD_RELEASE;
            else
                code = 3'($urandom_range(0, 7));
            run_seq(code, 8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // result side: random stalls, one long hold-off, always ready at the end
    initial
    begin : result_sink
        int unsigned n;
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_wanted && !hold_taken)
            begin
                out_ready <= 1'b0;
                hold_taken = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sccb_master_byte_writer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        in_t poke;
        int code;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, one tick per ordinary phase
        run_seq(CMD_START, 8'h00, 1'b0, 1'b0);
        run_seq(CMD_STOP, 8'h00, 1'b0, 1'b0);

        // unmapped register index must not disturb anything
        settle();
        write_reg(CFG_SPARE, 16'($urandom));

        // every command at short timing, both ack levels
        set_config(8'd1, 16'd2);
        run_seq(CMD_RELEASE, 8'h00, 1'b1, 1'b0);
        run_seq(CMD_START, 8'h00, 1'b1, 1'b0);
        run_seq(CMD_WRITE, 8'h00, 1'b1, 1'b0);
        run_seq(CMD_WRITE, 8'hff, 1'b0, 1'b0);
        run_seq(CMD_WRITE, 8'h80, 1'b0, 1'b0);
        run_seq(CMD_STOP, 8'hff, 1'b1, 1'b0);
        run_seq(CMD_IDLE, 8'h55, 1'b0, 1'b0);
        for (code = FUNC_RSVD_FIRST; code <= FUNC_RSVD_LAST; code++)
            run_seq(3'(code), 8'haa, 1'b1, 1'b0);

        // command while a write is running
        poke.func = CMD_WRITE;
        poke.wdata = 8'h3c;
        poke.sda_in = 1'b0;
        send_tick(poke);
        poke.func = CMD_START;
        send_tick(poke);
        settle();

        // command landing on the tick that finishes a release
        poke.func = CMD_RELEASE;
        send_tick(poke);
        poke.func = CMD_STOP;
        send_tick(poke);
        settle();

        // zero in both registers reads as one tick
        set_config(8'd0, 16'd0);
        run_seq(CMD_START, 8'h00, 1'b0, 1'b0);
        run_seq(CMD_WRITE, 8'h81, 1'b0, 1'b0);
        run_seq(CMD_STOP, 8'h00, 1'b1, 1'b0);

        // longer ordinary phases and a longer ack hold
        set_config(8'd6, 16'd150);
        run_seq(CMD_START, 8'h00, 1'b1, 1'b0);
        run_seq(CMD_WRITE, 8'h6e, 1'b1, 1'b0);
        run_seq(CMD_STOP, 8'h00, 1'b0, 1'b0);

        // random traffic, the receiver backs off once in the first round
        set_config(8'd1, 16'd1);
        hold_wanted = 1'b1;
        random_burst(BURST_TICKS);
        repeat (3)
        begin
            set_config(8'($urandom_range(1, 4)), 16'($urandom_range(1, 16)));
            random_burst(BURST_TICKS);
        end

        // closing round with no idling on either side
        set_config(8'd2, 16'd3);
        calm = 1'b1;
        random_burst(BURST_TICKS);
        settle();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && levels_owed == 0)
            $display("sccb_master_byte_writer regression: pass");
        else
            $display("sccb_master_byte_writer regression: fail");
        $finish;
    end

endmodule
